FILE: rtl/vertex_attribute_to_float_unit_macros.svh
// ----------------------------------------------------------------------------
// Vertex attribute to float unit: assertion macros
// Short forms for the concurrent checks that the unit places at its end.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ATTRIBUTE_TO_FLOAT_UNIT_MACROS_SVH
`define VERTEX_ATTRIBUTE_TO_FLOAT_UNIT_MACROS_SVH

// The consequent must hold in the cycle of the antecedent, outside reset.
`define VATF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define VATF_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent, reset included.
`define VATF_ASSERT_ANY(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vatf_pkg.sv
// ----------------------------------------------------------------------------
// Vertex attribute to float: shared package
// Format codes, lane classes, divisor constants and the lane result type.
// ----------------------------------------------------------------------------
`default_nettype none

package vatf_pkg;

    localparam logic [4:0] KIND_FLOAT1    = 5'd0;
    localparam logic [4:0] KIND_FLOAT2    = 5'd1;
    localparam logic [4:0] KIND_FLOAT3    = 5'd2;
    localparam logic [4:0] KIND_FLOAT4    = 5'd3;
    localparam logic [4:0] KIND_COLOR     = 5'd4;
    localparam logic [4:0] KIND_UBYTE4    = 5'd5;
    localparam logic [4:0] KIND_SHORT2    = 5'd6;
    localparam logic [4:0] KIND_SHORT4    = 5'd7;
    localparam logic [4:0] KIND_UBYTE4N   = 5'd8;
    localparam logic [4:0] KIND_SHORT2N   = 5'd9;
    localparam logic [4:0] KIND_SHORT4N   = 5'd10;
    localparam logic [4:0] KIND_USHORT2N  = 5'd11;
    localparam logic [4:0] KIND_USHORT4N  = 5'd12;
    localparam logic [4:0] KIND_FLOAT16_2 = 5'd15;
    localparam logic [4:0] KIND_FLOAT16_4 = 5'd16;

    localparam int LANES = 4;

    // What a lane does with its element.
    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_FLOAT,
        CLS_UNORM8,
        CLS_SINT16,
        CLS_SNORM16,
        CLS_UNORM16,
        CLS_HALF
    } cls_t;

    typedef enum logic [1:0] {
        DIV_255,
        DIV_32767,
        DIV_65535
    } div_t;

    // Quotient scale: Q = floor(a * 2^K / d), chosen so that Q has 26 or 27 bits.
    localparam int K_255   = 18;
    localparam int K_32767 = 25;
    localparam int K_65535 = 26;

    // Reciprocals floor(2^(16+K) / d).
    localparam logic [26:0] RECIP_255   = 27'((64'd1 << (16 + K_255)) / 64'd255);
    localparam logic [26:0] RECIP_32767 = 27'((64'd1 << (16 + K_32767)) / 64'd32767);
    localparam logic [26:0] RECIP_65535 = 27'((64'd1 << (16 + K_65535)) / 64'd65535);

    // Biased exponent of Q / 2^K when the leading quotient bit is bit 25.
    localparam logic [7:0] EBASE_255   = 8'(25 - K_255 + 127);
    localparam logic [7:0] EBASE_32767 = 8'(25 - K_32767 + 127);
    localparam logic [7:0] EBASE_65535 = 8'(25 - K_65535 + 127);

    typedef struct packed {
        logic        is_div;
        logic        sign;
        logic [7:0]  exp_base;
        logic [31:0] direct;
    } lane_meta_t;

    typedef struct packed {
        logic        is_div;
        logic        sign;
        logic [7:0]  exp_base;
        logic [26:0] quo;
        logic        sticky;
        logic [31:0] direct;
    } lane_res_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } lane_en_t;

endpackage

`default_nettype wire

FILE: rtl/vatf_lane.sv
// ----------------------------------------------------------------------------
// Vertex attribute to float: conversion lane
// Converts one element to a float, or to an unrounded quotient and sticky bit.
// ----------------------------------------------------------------------------
`default_nettype none

module vatf_lane
    import vatf_pkg::*;
(
    input  wire logic        aclk,
    input  wire lane_en_t    en,
    input  wire logic [31:0] elem_i,
    input  wire cls_t        cls_i,
    output lane_res_t        res_o
);

    function automatic logic [3:0] lzc16(input logic [15:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (v[k]) begin
                n = 4'(15 - k);
            end
        end
        return n;
    endfunction

    logic [31:0] s1_elem_reg;
    cls_t        s1_cls_reg;

    lane_meta_t  s2_meta_reg, s2_meta_next;
    div_t        s2_div_reg, s2_div_next;
    logic [15:0] s2_anorm_reg, s2_anorm_next;

    lane_meta_t  s3_meta_reg;
    div_t        s3_div_reg;
    logic [26:0] s3_q0_reg, s3_q0_next;

    lane_meta_t  s4_meta_reg;
    div_t        s4_div_reg;
    logic [26:0] s4_q0_reg;
    logic [17:0] s4_rem_reg, s4_rem_next;

    lane_res_t   s5_res_reg, s5_res_next;

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            s1_elem_reg <= elem_i;
            s1_cls_reg  <= cls_i;
        end
    end

    // Decode, normalise and the exact conversions.
    always_comb begin
        logic [15:0] h;
        logic [15:0] mag;
        logic [3:0]  lz;
        logic [3:0]  hlz;
        logic [15:0] hnorm;
        logic        sgn;
        h     = s1_elem_reg[15:0];
        sgn   = 1'b0;
        mag   = 16'd0;
        unique case (s1_cls_reg)
            CLS_SINT16, CLS_SNORM16: begin
                sgn = h[15];
                mag = h[15] ? (~h + 16'd1) : h;
            end
            CLS_UNORM16: mag = h;
            CLS_UNORM8:  mag = {8'd0, h[7:0]};
            default:     mag = 16'd0;
        endcase
        lz            = lzc16(mag);
        s2_anorm_next = mag << lz;
        hlz           = lzc16({6'd0, h[9:0]});
        hnorm         = {6'd0, h[9:0]} << hlz;

        s2_meta_next.is_div   = 1'b0;
        s2_meta_next.sign     = sgn;
        s2_meta_next.exp_base = EBASE_255 - {4'd0, lz};
        s2_meta_next.direct   = 32'd0;
        s2_div_next           = DIV_255;

        unique case (s1_cls_reg)
            CLS_FLOAT: s2_meta_next.direct = s1_elem_reg;
            CLS_SINT16: begin
                if (mag != 16'd0) begin
                    s2_meta_next.direct = {sgn, 8'd142 - {4'd0, lz}, s2_anorm_next[14:0], 8'd0};
                end
            end
            CLS_UNORM8: begin
                s2_meta_next.is_div = (mag != 16'd0);
            end
            CLS_SNORM16: begin
                s2_meta_next.is_div   = (mag != 16'd0);
                s2_meta_next.exp_base = EBASE_32767 - {4'd0, lz};
                s2_div_next           = DIV_32767;
            end
            CLS_UNORM16: begin
                s2_meta_next.is_div   = (mag != 16'd0);
                s2_meta_next.exp_base = EBASE_65535 - {4'd0, lz};
                s2_div_next           = DIV_65535;
            end
            CLS_HALF: begin
                if (h[14:10] == 5'd0) begin
                    if (h[9:0] == 10'd0) begin
                        s2_meta_next.direct = {h[15], 31'd0};
                    end else begin
                        s2_meta_next.direct = {h[15], 8'd118 - {4'd0, hlz}, hnorm[14:5], 13'd0};
                    end
                end else if (h[14:10] == 5'h1F) begin
                    s2_meta_next.direct = {h[15], 8'hFF, h[9:0], 13'd0};
                end else begin
                    s2_meta_next.direct = {h[15], {3'd0, h[14:10]} + 8'd112, h[9:0], 13'd0};
                end
            end
            default: s2_meta_next.direct = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            s2_meta_reg  <= s2_meta_next;
            s2_div_reg   <= s2_div_next;
            s2_anorm_reg <= s2_anorm_next;
        end
    end

    // Estimated quotient, at most one below the true one.
    always_comb begin
        logic [26:0] recip;
        logic [42:0] prod;
        unique case (s2_div_reg)
            DIV_32767: recip = RECIP_32767;
            DIV_65535: recip = RECIP_65535;
            default:   recip = RECIP_255;
        endcase
        prod       = {27'd0, s2_anorm_reg} * {16'd0, recip};
        s3_q0_next = prod[42:16];
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            s3_meta_reg <= s2_meta_reg;
            s3_div_reg  <= s2_div_reg;
            s3_q0_reg   <= s3_q0_next;
        end
    end

    // The dividend has at least 18 zero low bits, so the remainder is the
    // negated low part of the quotient times the divisor.
    always_comb begin
        logic [15:0] dval;
        logic [33:0] low;
        unique case (s3_div_reg)
            DIV_32767: dval = 16'd32767;
            DIV_65535: dval = 16'd65535;
            default:   dval = 16'd255;
        endcase
        low         = {16'd0, s3_q0_reg[17:0]} * {18'd0, dval};
        s4_rem_next = 18'd0 - low[17:0];
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            s4_meta_reg <= s3_meta_reg;
            s4_div_reg  <= s3_div_reg;
            s4_q0_reg   <= s3_q0_reg;
            s4_rem_reg  <= s4_rem_next;
        end
    end

    always_comb begin
        logic [17:0] dval;
        logic [17:0] rem;
        unique case (s4_div_reg)
            DIV_32767: dval = 18'd32767;
            DIV_65535: dval = 18'd65535;
            default:   dval = 18'd255;
        endcase
        s5_res_next.is_div   = s4_meta_reg.is_div;
        s5_res_next.sign     = s4_meta_reg.sign;
        s5_res_next.exp_base = s4_meta_reg.exp_base;
        s5_res_next.direct   = s4_meta_reg.direct;
        if (s4_rem_reg >= dval) begin
            s5_res_next.quo = s4_q0_reg + 27'd1;
            rem             = s4_rem_reg - dval;
        end else begin
            s5_res_next.quo = s4_q0_reg;
            rem             = s4_rem_reg;
        end
        s5_res_next.sticky = (rem != 18'd0);
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            s5_res_reg <= s5_res_next;
        end
    end

    assign res_o = s5_res_reg;

endmodule

`default_nettype wire

FILE: rtl/vatf_merge.sv
// ----------------------------------------------------------------------------
// Vertex attribute to float: merging stage
// Rounds the lane quotients to nearest even and registers all four components.
// ----------------------------------------------------------------------------
`default_nettype none

module vatf_merge
    import vatf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      en,
    input  wire lane_res_t lane_res_i [LANES],
    output logic [31:0]    comp_o     [LANES]
);

    function automatic logic [31:0] pack(input lane_res_t r);
        logic [23:0] mant;
        logic        g;
        logic        st;
        logic [7:0]  e;
        logic [24:0] mr;
        logic [22:0] frac;
        if (r.quo[26]) begin
            mant = r.quo[26:3];
            g    = r.quo[2];
            st   = (|r.quo[1:0]) | r.sticky;
            e    = r.exp_base + 8'd1;
        end else begin
            mant = r.quo[25:2];
            g    = r.quo[1];
            st   = r.quo[0] | r.sticky;
            e    = r.exp_base;
        end
        mr = {1'b0, mant} + {24'd0, g & (st | mant[0])};
        if (mr[24]) begin
            e    = e + 8'd1;
            frac = mr[23:1];
        end else begin
            frac = mr[22:0];
        end
        return r.is_div ? {r.sign, e, frac} : r.direct;
    endfunction

    logic [31:0] comp_reg [LANES];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                comp_reg[i] <= pack(lane_res_i[i]);
            end
        end
    end

    assign comp_o = comp_reg;

endmodule

`default_nettype wire

FILE: rtl/vertex_attribute_to_float_unit.sv
// ----------------------------------------------------------------------------
// Vertex attribute to float unit
// Converts one vertex attribute (format code plus up to sixteen raw bytes)
// into four IEEE single-precision components, one attribute per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Ports                                       Role
//   s_        in          s_kind, s_raw_low, s_raw_high, s_bytes_valid attribute
//   m_        out         m_comp_x, m_comp_y, m_comp_z, m_comp_w       four floats
//
// From acceptance to m_valid a transfer passes the lane stages and the merge register.
// A new attribute is taken every cycle while s_ready is high; four lanes convert
// the elements in parallel, dividing by reciprocal multiply and correction.
// Reset (aresetn, synchronous, active low) empties the pipeline only.
// Each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and the input stays ready as long as any stage is empty.
//
// ----------------------------------------------------------------------------
`default_nettype none

`include "vertex_attribute_to_float_unit_macros.svh"

module vertex_attribute_to_float_unit
    import vatf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [4:0]  s_kind,
    input  wire logic [63:0] s_raw_low,
    input  wire logic [63:0] s_raw_high,
    input  wire logic [4:0]  s_bytes_valid,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_comp_x,
    output logic [31:0]      m_comp_y,
    output logic [31:0]      m_comp_z,
    output logic [31:0]      m_comp_w
);

    // Five lane stages and the output register of the merging stage.
    localparam int STAGES = 6;

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] adv;

    logic [127:0] raw;
    logic [4:0]   vclip;

    logic [31:0]  lane_elem [LANES];
    cls_t         lane_cls  [LANES];
    lane_res_t    lane_res  [LANES];
    logic [31:0]  comp      [LANES];
    lane_en_t     lane_en;

    // A stage may load when it is empty or when its contents move on.
    always_comb begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[STAGES-1];

    always_comb begin
        valid_next = valid_reg;
        if (adv[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign lane_en.s1 = adv[0];
    assign lane_en.s2 = adv[1];
    assign lane_en.s3 = adv[2];
    assign lane_en.s4 = adv[3];
    assign lane_en.s5 = adv[4];

    assign raw   = {s_raw_high, s_raw_low};
    assign vclip = (s_bytes_valid > 5'd16) ? 5'd16 : s_bytes_valid;

    // Element fetch: each lane picks its element from the byte array. An
    // element that runs past the valid byte count is fetched as zero, and a
    // component the format does not supply is forced to zero.
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        always_comb begin
            lane_elem[i] = 32'd0;
            lane_cls[i]  = CLS_ZERO;
            case (s_kind) inside
                KIND_FLOAT1, KIND_FLOAT2, KIND_FLOAT3, KIND_FLOAT4: begin
                    lane_cls[i] = CLS_FLOAT;
                    if ((5'(i) <= s_kind) && (5'(4 * i + 4) <= vclip)) begin
                        lane_elem[i] = raw[32*i +: 32];
                    end
                end
                KIND_COLOR, KIND_UBYTE4, KIND_UBYTE4N: begin
                    lane_cls[i] = CLS_UNORM8;
                    if (5'(i + 1) <= vclip) begin
                        lane_elem[i] = {24'd0, raw[8*i +: 8]};
                    end
                end
                KIND_SHORT2, KIND_SHORT4, KIND_SHORT2N, KIND_SHORT4N,
                KIND_USHORT2N, KIND_USHORT4N, KIND_FLOAT16_2, KIND_FLOAT16_4: begin
                    if ((i < 2) || (s_kind == KIND_SHORT4) || (s_kind == KIND_SHORT4N)
                            || (s_kind == KIND_USHORT4N) || (s_kind == KIND_FLOAT16_4)) begin
                        if ((s_kind == KIND_SHORT2) || (s_kind == KIND_SHORT4)) begin
                            lane_cls[i] = CLS_SINT16;
                        end else if ((s_kind == KIND_SHORT2N) || (s_kind == KIND_SHORT4N)) begin
                            lane_cls[i] = CLS_SNORM16;
                        end else if ((s_kind == KIND_USHORT2N)
                                || (s_kind == KIND_USHORT4N)) begin
                            lane_cls[i] = CLS_UNORM16;
                        end else begin
                            lane_cls[i] = CLS_HALF;
                        end
                        if (5'(2 * i + 2) <= vclip) begin
                            lane_elem[i] = {16'd0, raw[16*i +: 16]};
                        end
                    end
                end
                default: lane_cls[i] = CLS_ZERO;
            endcase
        end

        vatf_lane u_lane (
            .aclk   (aclk),
            .en     (lane_en),
            .elem_i (lane_elem[i]),
            .cls_i  (lane_cls[i]),
            .res_o  (lane_res[i])
        );
    end

    vatf_merge u_merge (
        .aclk       (aclk),
        .en         (adv[STAGES-1]),
        .lane_res_i (lane_res),
        .comp_o     (comp)
    );

    assign m_comp_x = comp[0];
    assign m_comp_y = comp[1];
    assign m_comp_z = comp[2];
    assign m_comp_w = comp[3];

    `VATF_ASSERT_NXT(a_accept_fills, aclk, aresetn, s_valid && s_ready, valid_reg[0], "accepted transfer lost at first stage")
    `VATF_ASSERT_NXT(a_stall_holds, aclk, aresetn, valid_reg[2] && !adv[2], valid_reg[2], "stalled stage dropped its item")
    `VATF_ASSERT_NXT(a_taken_clears, aclk, aresetn, m_valid && m_ready && !valid_reg[STAGES-2], !m_valid, "result repeated after transfer")
    `VATF_ASSERT_ANY(a_reset_empty, aclk, !aresetn, valid_reg == '0, "pipeline not empty after reset")

endmodule

`default_nettype wire
